### hdl/mtts_pkg.sv
package mtts_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SNAP_EPS = 7;
  localparam int MS_PER_S = 1000;
  localparam int ONE = 1 << FRAC_BITS;

  // ceil(2^58 / 1000) gives an exact floor division by 1000 for dividends below 2^48.
  localparam logic [48:0] RECIP_MS = 49'd288230376151712;
  localparam int RECIP_SHIFT = 58;

  localparam logic [2:0] REG_TARGET_X = 3'd0;
  localparam logic [2:0] REG_TARGET_Y = 3'd1;
  localparam logic [2:0] REG_SPEED = 3'd2;
  localparam logic [2:0] REG_EASE_MODE = 3'd3;
  localparam logic [2:0] REG_DURATION = 3'd4;

endpackage

### hdl/move_to_target_stepper.sv
// Channel  Direction  Handshake               Payload
// in       sink       in_valid / in_stall     delta_ms, current_x, current_y, object_gone
// out      source     out_valid / out_stall   new_x, new_y, position_valid, finished
// cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A finished or abandoned tick skips all arithmetic. An ease tick finds t by a 16-step
// restoring division, which it skips when its duration is zero or its time is up. A
// velocity tick divides by 1000 with a reciprocal multiply, then runs 32 steps of the
// square root and, unless it snaps, 2 x 48 steps of the multiply-divide, in turn.
// in_stall is high from acceptance until the result is moved to the output register,
// which waits while out_stall holds an earlier result. Reset is synchronous.
module move_to_target_stepper (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] delta_ms,
  input  logic [31:0] current_x,
  input  logic [31:0] current_y,
  input  logic        object_gone,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] new_x,
  output logic [31:0] new_y,
  output logic        position_valid,
  output logic        finished,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mtts_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_START  = 5'd1;
  localparam logic [4:0] S_EMIN   = 5'd2;
  localparam logic [4:0] S_EDIV   = 5'd3;
  localparam logic [4:0] S_ECHK   = 5'd4;
  localparam logic [4:0] S_ET2    = 5'd5;
  localparam logic [4:0] S_ES     = 5'd6;
  localparam logic [4:0] S_ENX    = 5'd7;
  localparam logic [4:0] S_ENY    = 5'd8;
  localparam logic [4:0] S_VSQ1   = 5'd9;
  localparam logic [4:0] S_VSQ2   = 5'd10;
  localparam logic [4:0] S_VLOAD  = 5'd11;
  localparam logic [4:0] S_VSTEPD = 5'd12;
  localparam logic [4:0] S_VSQRT  = 5'd13;
  localparam logic [4:0] S_VSNAP  = 5'd14;
  localparam logic [4:0] S_VMDX   = 5'd15;
  localparam logic [4:0] S_VMDY   = 5'd16;
  localparam logic [4:0] S_WB     = 5'd17;

  localparam int F = FRAC_BITS;

  logic [4:0]  state;
  logic [31:0] target_x, target_y, speed;
  logic        ease_mode;
  logic [23:0] move_duration_ms;
  logic [31:0] start_x, start_y, elapsed_ms;
  logic        started, done;
  logic [15:0] delta;
  logic [31:0] cur_x, cur_y;
  logic        gone;
  logic signed [67:0] prod;
  logic signed [33:0] ma, mb;
  logic [63:0] acc, sv, sres, sbit;
  logic [35:0] rem;
  logic [47:0] quo, sh;
  logic [5:0]  cnt;
  logic [39:0] step;
  logic [F+1:0] sval;
  logic [31:0] mx;
  logic [31:0] res_x, res_y;
  logic        res_v, res_f;
  logic [97:0] racc, rc_add;
  logic [39:0] step_q;

  logic [32:0] dx, dy, ax, ay, diffx, diffy;
  logic        big;
  logic [31:0] hx, hy;
  logic [33:0] distance;
  logic [32:0] e_sum;
  logic [31:0] e_sat;
  logic [F-1:0] t;
  logic [F+1:0] kval;
  logic [24:0] dv_r2;
  logic        dv_ge;
  logic [63:0] sq_t;
  logic        sq_ge;
  logic [35:0] md_d, md_d2, md_d3, md_r2, md_sub;
  logic [32:0] md_a;
  logic [1:0]  md_dig;
  logic [47:0] md_q;
  logic        accept, out_free;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || !out_stall;

  assign dx = {target_x[31], target_x} - {cur_x[31], cur_x};
  assign dy = {target_y[31], target_y} - {cur_y[31], cur_y};
  assign ax = dx[32] ? -dx : dx;
  assign ay = dy[32] ? -dy : dy;
  assign big = (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);
  assign hx = big ? ax[32:1] : ax[31:0];
  assign hy = big ? ay[32:1] : ay[31:0];
  assign distance = big ? {sres[32:0], 1'b0} : {1'b0, sres[32:0]};
  assign diffx = {target_x[31], target_x} - {start_x[31], start_x};
  assign diffy = {target_y[31], target_y} - {start_y[31], start_y};

  assign e_sum = {1'b0, elapsed_ms} + {17'b0, delta};
  assign e_sat = e_sum[32] ? 32'hFFFF_FFFF : e_sum[31:0];

  assign t = quo[F-1:0];
  assign kval = (F+2)'(3 * ONE) - {1'b0, t, 1'b0};

  assign dv_r2 = {rem[23:0], 1'b0};
  assign dv_ge = dv_r2 >= {1'b0, move_duration_ms};

  assign step_q = racc[RECIP_SHIFT+39:RECIP_SHIFT];

  always_comb begin
    case (cnt)
      6'd4: rc_add = {34'b0, prod[63:0]};
      6'd3, 6'd2: rc_add = {2'b0, prod[63:0], 32'b0};
      6'd1: rc_add = {prod[33:0], 64'b0};
      default: rc_add = '0;
    endcase
  end

  assign sq_t = sres + sbit;
  assign sq_ge = sv >= sq_t;

  assign md_a = (state == S_VMDX) ? ax : ay;
  assign md_d = {2'b0, distance};
  assign md_d2 = {md_d[34:0], 1'b0};
  assign md_d3 = md_d + md_d2;
  assign md_r2 = {rem[34:0], 1'b0} + (sh[47] ? {3'b0, md_a} : 36'd0);

  always_comb begin
    if (md_r2 >= md_d3) begin
      md_dig = 2'd3;
      md_sub = md_d3;
    end else if (md_r2 >= md_d2) begin
      md_dig = 2'd2;
      md_sub = md_d2;
    end else if (md_r2 >= md_d) begin
      md_dig = 2'd1;
      md_sub = md_d;
    end else begin
      md_dig = 2'd0;
      md_sub = 36'd0;
    end
  end

  assign md_q = {quo[46:0], 1'b0} + {46'b0, md_dig};

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_START: begin
        ma = {2'b0, hx};
        mb = {2'b0, hx};
      end
      S_VSQ1: begin
        ma = {2'b0, hy};
        mb = {2'b0, hy};
      end
      S_VSQ2: begin
        ma = {2'b0, speed};
        mb = {18'b0, delta};
      end
      S_VSTEPD: begin
        case (cnt)
          6'd5, 6'd4: ma = {2'b0, sh[31:0]};
          default: ma = {18'b0, sh[47:32]};
        endcase
        case (cnt)
          6'd5, 6'd3: mb = {2'b0, RECIP_MS[31:0]};
          default: mb = {17'b0, RECIP_MS[48:32]};
        endcase
      end
      S_ECHK: begin
        ma = 34'(t);
        mb = 34'(t);
      end
      S_ET2: begin
        ma = 34'(prod[2*F-1:F]);
        mb = 34'(kval);
      end
      S_ES: begin
        ma = {diffx[32], diffx};
        mb = 34'(prod[2*F+1:F]);
      end
      S_ENX: begin
        ma = {diffy[32], diffy};
        mb = 34'(sval);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_y <= '0;
      speed <= '0;
      ease_mode <= 1'b0;
      move_duration_ms <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_X: target_x <= cfg_data;
        REG_TARGET_Y: target_y <= cfg_data;
        REG_SPEED: speed <= cfg_data;
        REG_EASE_MODE: ease_mode <= cfg_data[0];
        REG_DURATION: move_duration_ms <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start_x <= '0;
      start_y <= '0;
      elapsed_ms <= '0;
      started <= 1'b0;
      done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_WB) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            delta <= delta_ms;
            cur_x <= current_x;
            cur_y <= current_y;
            gone <= object_gone;
            state <= S_START;
          end
        end
        S_START: begin
          if (done || gone) begin
            done <= 1'b1;
            res_x <= '0;
            res_y <= '0;
            res_v <= 1'b0;
            res_f <= 1'b1;
            state <= S_WB;
          end else if (ease_mode) begin
            if (!started) begin
              start_x <= cur_x;
              start_y <= cur_y;
              started <= 1'b1;
            end
            if (move_duration_ms == 24'd0) begin
              done <= 1'b1;
              res_x <= target_x;
              res_y <= target_y;
              res_v <= 1'b1;
              res_f <= 1'b1;
              state <= S_WB;
            end else begin
              elapsed_ms <= e_sat;
              state <= S_EMIN;
            end
          end else begin
            state <= S_VSQ1;
          end
        end
        S_EMIN: begin
          if (elapsed_ms >= {8'b0, move_duration_ms}) begin
            done <= 1'b1;
            res_x <= target_x;
            res_y <= target_y;
            res_v <= 1'b1;
            res_f <= 1'b1;
            state <= S_WB;
          end else begin
            rem <= {12'b0, elapsed_ms[23:0]};
            quo <= '0;
            cnt <= 6'(F);
            state <= S_EDIV;
          end
        end
        S_EDIV: begin
          rem <= dv_ge ? 36'(dv_r2 - {1'b0, move_duration_ms}) : 36'(dv_r2);
          quo <= {quo[46:0], dv_ge};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_ECHK;
          end
        end
        S_ECHK: begin
          if (t >= F'(ONE - SNAP_EPS)) begin
            done <= 1'b1;
            res_x <= target_x;
            res_y <= target_y;
            res_v <= 1'b1;
            res_f <= 1'b1;
            state <= S_WB;
          end else begin
            state <= S_ET2;
          end
        end
        S_ET2: begin
          state <= S_ES;
        end
        S_ES: begin
          sval <= prod[2*F+1:F];
          state <= S_ENX;
        end
        S_ENX: begin
          res_x <= start_x + prod[F+31:F];
          state <= S_ENY;
        end
        S_ENY: begin
          res_y <= start_y + prod[F+31:F];
          res_v <= 1'b1;
          res_f <= 1'b0;
          state <= S_WB;
        end
        S_VSQ1: begin
          acc <= prod[63:0];
          state <= S_VSQ2;
        end
        S_VSQ2: begin
          sv <= acc + prod[63:0];
          sres <= '0;
          sbit <= 64'h4000_0000_0000_0000;
          state <= S_VLOAD;
        end
        S_VLOAD: begin
          sh <= prod[47:0];
          racc <= '0;
          cnt <= 6'd5;
          state <= S_VSTEPD;
        end
        S_VSTEPD: begin
          racc <= racc + rc_add;
          if (cnt == 6'd1) begin
            cnt <= 6'd32;
            state <= S_VSQRT;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_VSQRT: begin
          if (sq_ge) begin
            sv <= sv - sq_t;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_VSNAP;
          end
        end
        S_VSNAP: begin
          if ({7'b0, distance} <= {1'b0, step_q} + 41'(SNAP_EPS)) begin
            done <= 1'b1;
            res_x <= target_x;
            res_y <= target_y;
            res_v <= 1'b1;
            res_f <= 1'b1;
            state <= S_WB;
          end else begin
            step <= step_q;
            sh <= {8'b0, step_q};
            rem <= '0;
            quo <= '0;
            cnt <= 6'd48;
            state <= S_VMDX;
          end
        end
        S_VMDX, S_VMDY: begin
          if (cnt == 6'd1) begin
            if (state == S_VMDX) begin
              mx <= md_q[31:0];
              sh <= {8'b0, step};
              rem <= '0;
              quo <= '0;
              cnt <= 6'd48;
              state <= S_VMDY;
            end else begin
              res_x <= dx[32] ? cur_x - mx : cur_x + mx;
              res_y <= dy[32] ? cur_y - md_q[31:0] : cur_y + md_q[31:0];
              res_v <= 1'b1;
              res_f <= 1'b0;
              state <= S_WB;
            end
          end else begin
            rem <= md_r2 - md_sub;
            quo <= md_q;
            sh <= {sh[46:0], 1'b0};
            cnt <= cnt - 6'd1;
          end
        end
        S_WB: begin
          if (out_free) begin
            new_x <= res_x;
            new_y <= res_y;
            position_valid <= res_v;
            finished <= res_f;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_sticky: assert property (@(posedge clk) disable iff (rst) done |=> done)
    else $error("done flag cleared without reset");
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_START)
    else $error("accepted transaction did not start processing");
  a_invalid_is_finished: assert property (@(posedge clk) disable iff (rst)
    out_valid && !position_valid |-> finished)
    else $error("result without position is not finished");
  a_wb_load: assert property (@(posedge clk) disable iff (rst)
    state == S_WB && out_free |=> out_valid && state == S_IDLE)
    else $error("result not moved to output register");
`endif

endmodule

### verif/move_to_target_stepper_checker.sv
`timescale 1ns / 1ps

module move_to_target_stepper_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] delta_ms,
  input  logic [31:0] current_x,
  input  logic [31:0] current_y,
  input  logic        object_gone,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] new_x,
  input  logic [31:0] new_y,
  input  logic        position_valid,
  input  logic        finished,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          ticks_seen
);
  import mtts_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        pos_valid;
    logic        fin;
  } move_t;

  move_t expected_moves[$];

  logic [31:0] tgt_x, tgt_y, spd;
  logic        ease;
  logic [23:0] dur;
  logic [31:0] org_x, org_y, elapsed;
  logic        latched, over;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic move_t next_move(logic [15:0] dms, logic [31:0] cx, logic [31:0] cy,
                                      logic gone);
    move_t       m;
    longint      tx, ty, px, py, dx, dy;
    logic [63:0] ax, ay, distance, step, e, t, t2, s, mx, my;
    logic [127:0] p;
    localparam logic [63:0] UNIT = 64'd1 << FRAC_BITS;
    tx = longint'($signed(tgt_x));
    ty = longint'($signed(tgt_y));
    px = longint'($signed(cx));
    py = longint'($signed(cy));
    m = '{x: 32'd0, y: 32'd0, pos_valid: 1'b0, fin: 1'b1};
    if (over) return m;
    if (gone) begin
      over = 1'b1;
      return m;
    end
    m = '{x: tgt_x, y: tgt_y, pos_valid: 1'b1, fin: 1'b1};
    if (ease) begin
      if (!latched) begin
        org_x = cx;
        org_y = cy;
        latched = 1'b1;
      end
      if (dur == 0) begin
        over = 1'b1;
        return m;
      end
      e = {32'd0, elapsed} + {48'd0, dms};
      elapsed = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
      e = (elapsed < {8'd0, dur}) ? {32'd0, elapsed} : {40'd0, dur};
      t = (e << FRAC_BITS) / {40'd0, dur};
      if (t + SNAP_EPS >= UNIT) begin
        over = 1'b1;
        return m;
      end
      t2 = (t * t) >> FRAC_BITS;
      s = (t2 * (3 * UNIT - 2 * t)) >> FRAC_BITS;
      dx = longint'($signed(org_x));
      dy = longint'($signed(org_y));
      m.x = 32'(dx + (((tx - dx) * longint'(s)) >>> FRAC_BITS));
      m.y = 32'(dy + (((ty - dy) * longint'(s)) >>> FRAC_BITS));
      m.fin = 1'b0;
      return m;
    end
    dx = tx - px;
    dy = ty - py;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax > 64'h7FFF_FFFF || ay > 64'h7FFF_FFFF)
      distance = 2 * int_sqrt((ax >> 1) * (ax >> 1) + (ay >> 1) * (ay >> 1));
    else
      distance = int_sqrt(ax * ax + ay * ay);
    step = ({32'd0, spd} * {48'd0, dms}) / MS_PER_S;
    if (distance <= step + SNAP_EPS) begin
      over = 1'b1;
      return m;
    end
    p = {64'd0, ax} * {64'd0, step};
    mx = 64'(p / {64'd0, distance});
    p = {64'd0, ay} * {64'd0, step};
    my = 64'(p / {64'd0, distance});
    m.x = 32'((dx < 0) ? px - longint'(mx) : px + longint'(mx));
    m.y = 32'((dy < 0) ? py - longint'(my) : py + longint'(my));
    m.fin = 1'b0;
    return m;
  endfunction

  always @(negedge clk) begin
    move_t got, want;
    if (rst) begin
      tgt_x = 0; tgt_y = 0; spd = 0; ease = 0; dur = 0;
      org_x = 0; org_y = 0; elapsed = 0; latched = 0; over = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{x: new_x, y: new_y, pos_valid: position_valid, fin: finished};
        if (expected_moves.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result transaction: %h", got);
        end else begin
          want = expected_moves.pop_front();
          ticks_seen++;
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: expected x=%h y=%h pv=%b fin=%b, got x=%h y=%h pv=%b fin=%b",
                       want.x, want.y, want.pos_valid, want.fin,
                       got.x, got.y, got.pos_valid, got.fin);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_moves.push_back(next_move(delta_ms, current_x, current_y, object_gone));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_X:  tgt_x = cfg_data;
          REG_TARGET_Y:  tgt_y = cfg_data;
          REG_SPEED:     spd = cfg_data;
          REG_EASE_MODE: ease = cfg_data[0];
          REG_DURATION:  dur = cfg_data[23:0];
          default: ;
        endcase
      end
    end
    pending = expected_moves.size();
  end

endmodule

### verif/move_to_target_stepper_tb.sv
`timescale 1ns / 1ps

module move_to_target_stepper_tb;
  import mtts_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] delta_ms = '0;
  logic [31:0] current_x = '0;
  logic [31:0] current_y = '0;
  logic        object_gone = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] new_x, new_y;
  logic        position_valid, finished;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int errors, pending, ticks_seen;
  int cycles = 0;
  bit quiet = 1'b0;

  always #2 clk = ~clk;

  move_to_target_stepper DUT (.*);

  move_to_target_stepper_checker checker_i (.*);

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 22);
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding.", pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_tick(logic [15:0] dms, logic [31:0] cx, logic [31:0] cy, logic gone);
    if (!quiet) begin
      while ($urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    delta_ms <= dms;
    current_x <= cx;
    current_y <= cy;
    object_gone <= gone;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic end_writes;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Places the object at least 2^27 LSBs from the target in x, which keeps every
  // velocity step short of the snap distance while speed stays below 2^20.
  task automatic far_tick(logic [31:0] tx, logic [15:0] dms);
    logic [31:0] off;
    off = $urandom_range(32'h7FFF_FFFF, 32'h0800_0000);
    if ($urandom_range(1)) off = -off;
    send_tick(dms, tx + off, $urandom, 1'b0);
  endtask

  initial begin
    logic [31:0] tx;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_TARGET_X, 32'h7FFF_FFFF);
    write_reg(REG_TARGET_Y, 32'h8000_0000);
    write_reg(REG_SPEED, 32'hFFFF_FFFF);
    write_reg(REG_EASE_MODE, 32'd0);
    write_reg(REG_DURATION, 32'h00FF_FFFF);
    end_writes();
    send_tick(16'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_tick(16'd0, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_tick(16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    drain();
    write_reg(REG_SPEED, 32'h0000_1000);
    end_writes();
    send_tick(16'hFFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
    send_tick(16'hFFFF, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      tx = $urandom;
      write_reg(REG_TARGET_X, tx);
      write_reg(REG_TARGET_Y, $urandom);
      write_reg(REG_SPEED, (ph == 0) ? 32'h000F_FFFF : $urandom_range(32'h000F_FFFF));
      end_writes();
      quiet = (ph == 3);
      for (int i = 0; i < 100; i++)
        far_tick(tx, ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom));
      quiet = 1'b0;
    end

    drain();
    write_reg(REG_EASE_MODE, 32'd1);
    end_writes();
    send_tick(16'd0, $urandom, $urandom, 1'b0);
    send_tick(16'hFFFF, $urandom, $urandom, 1'b0);
    for (int i = 0; i < 250; i++) begin
      if (i == 125) begin
        drain();
        write_reg(REG_TARGET_X, $urandom);
        write_reg(REG_TARGET_Y, $urandom);
        write_reg(REG_SPEED, $urandom);
        end_writes();
      end
      send_tick(16'($urandom_range(40000)), $urandom, $urandom, 1'b0);
    end

    drain();
    write_reg(REG_DURATION, 32'd0);
    end_writes();
    send_tick(16'($urandom), $urandom, $urandom, 1'b0);
    for (int i = 0; i < 20; i++)
      send_tick(16'($urandom), $urandom, $urandom, 1'($urandom_range(1)));
    send_tick(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    drain();
    repeat (300) @(posedge clk);
    $display("Checked %0d ticks: directed extremes, velocity moves over eight settings,", ticks_seen);
    $display("a smoothstep move with a mid-move retarget, a zero-duration snap and finished ticks.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches.", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### move_to_target_stepper.f
hdl/mtts_pkg.sv
hdl/move_to_target_stepper.sv
verif/move_to_target_stepper_checker.sv
verif/move_to_target_stepper_tb.sv
